>>> src/escaped_string_decoder_assert.svh
// ============================================================================
// escaped_string_decoder_assert.svh
// Assertion macros for the escaped string decoder (clk / rst_n in scope).
// ============================================================================
`ifndef ESCAPED_STRING_DECODER_ASSERT_SVH
`define ESCAPED_STRING_DECODER_ASSERT_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define ESD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("escaped_string_decoder: same-cycle check failed");

// ante holds in a cycle -> cons holds in the next cycle
`define ESD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("escaped_string_decoder: next-cycle check failed");

`endif

>>> src/esd_pkg.sv
// ============================================================================
// esd_pkg
// Types, codes and helper functions shared by the escaped string decoder.
// ============================================================================
`default_nettype none

package esd_pkg;

  typedef enum logic [2:0] {
    MODE_PLAIN  = 3'd0,
    MODE_BSLASH = 3'd1,
    MODE_HEX_X  = 3'd2,
    MODE_HEX_U4 = 3'd3,
    MODE_HEX_U8 = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_DANGLING   = 3'd1,
    ST_TRUNCATED  = 3'd2,
    ST_BAD_LETTER = 3'd3,
    ST_BAD_HEX    = 3'd4,
    ST_RANGE      = 3'd5
  } status_t;

  localparam logic [7:0]  CH_BSLASH = 8'h5C;
  localparam logic [7:0]  CH_QUOTE  = 8'h22;
  localparam logic [7:0]  CH_LOW_X  = 8'h78;
  localparam logic [7:0]  CH_LOW_U  = 8'h75;
  localparam logic [7:0]  CH_UP_U   = 8'h55;
  localparam logic [31:0] CP_MAX    = 32'h0010_FFFF;

  // all results of one input transaction; bytes[0] goes out first
  typedef struct packed {
    logic [2:0]      num;
    logic [3:0][7:0] bytes;
    logic            has;
    status_t         status;
    logic            str_end;
  } res_t;

  typedef struct packed {
    mode_t mode;
    logic  disc;
  } dec_state_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } esc_t;

  typedef struct packed {
    logic [2:0]      num;
    logic [3:0][7:0] bytes;
  } utf8_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h37);
    end
    return h;
  endfunction

  function automatic esc_t escape_char(input logic [7:0] c);
    esc_t e;
    e.ok = 1'b1;
    unique case (c)
      CH_QUOTE:  e.val = 8'h22;
      CH_BSLASH: e.val = 8'h5C;
      8'h62:     e.val = 8'h08;  // b
      8'h66:     e.val = 8'h0C;  // f
      8'h6E:     e.val = 8'h0A;  // n
      8'h72:     e.val = 8'h0D;  // r
      8'h74:     e.val = 8'h09;  // t
      8'h61:     e.val = 8'h07;  // a
      8'h76:     e.val = 8'h0B;  // v
      8'h65:     e.val = 8'h1B;  // e -> ESC
      default: begin
        e.ok  = 1'b0;
        e.val = 8'h00;
      end
    endcase
    return e;
  endfunction

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t u;
    u = '0;
    if (cp[20:7] == '0) begin
      u.num      = 3'd1;
      u.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp[20:11] == '0) begin
      u.num      = 3'd2;
      u.bytes[0] = {3'b110, cp[10:6]};
      u.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp[20:16] == '0) begin
      u.num      = 3'd3;
      u.bytes[0] = {4'b1110, cp[15:12]};
      u.bytes[1] = {2'b10, cp[11:6]};
      u.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      u.num      = 3'd4;
      u.bytes[0] = {5'b11110, cp[20:18]};
      u.bytes[1] = {2'b10, cp[17:12]};
      u.bytes[2] = {2'b10, cp[11:6]};
      u.bytes[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

`default_nettype wire

>>> src/esd_decode.sv
// ============================================================================
// esd_decode
// Escape state and single-pass decode of one byte into up to four results.
// ============================================================================
`default_nettype none

module esd_decode
  import esd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output res_t            res,
  output dec_state_t      state_o
);

  mode_t       mode_r, mode_nxt;
  logic [2:0]  seen_r, seen_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        disc_r, disc_nxt;

  hex_t        hx;
  esc_t        esc;
  utf8_t       enc;
  logic [31:0] cp;
  logic [3:0]  seen_inc;
  logic [3:0]  need;

  assign hx       = hex_value(in_byte);
  assign esc      = escape_char(in_byte);
  assign cp       = {acc_r[27:0], hx.val};
  assign enc      = utf8_enc(cp[20:0]);
  assign seen_inc = {1'b0, seen_r} + 4'd1;

  always_comb begin
    unique case (mode_r)
      MODE_HEX_X:  need = 4'd2;
      MODE_HEX_U4: need = 4'd4;
      default:     need = 4'd8;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    seen_nxt = seen_r;
    acc_nxt  = acc_r;
    disc_nxt = disc_r;
    res      = '0;

    if (!disc_r) begin
      unique case (mode_r)
        MODE_PLAIN: begin
          if (in_byte == CH_BSLASH) begin
            if (in_last) begin
              res.num    = 3'd1;
              res.status = ST_DANGLING;
              disc_nxt   = 1'b1;
            end else begin
              mode_nxt = MODE_BSLASH;
            end
          end else begin
            res.num      = 3'd1;
            res.has      = 1'b1;
            res.bytes[0] = in_byte;
          end
        end
        MODE_BSLASH: begin
          mode_nxt = MODE_PLAIN;
          seen_nxt = '0;
          acc_nxt  = '0;
          if (esc.ok) begin
            res.num      = 3'd1;
            res.has      = 1'b1;
            res.bytes[0] = esc.val;
          end else if (in_byte == CH_LOW_X || in_byte == CH_LOW_U || in_byte == CH_UP_U) begin
            if (in_last) begin
              res.num    = 3'd1;
              res.status = ST_TRUNCATED;
              disc_nxt   = 1'b1;
            end else if (in_byte == CH_LOW_X) begin
              mode_nxt = MODE_HEX_X;
            end else if (in_byte == CH_LOW_U) begin
              mode_nxt = MODE_HEX_U4;
            end else begin
              mode_nxt = MODE_HEX_U8;
            end
          end else begin
            res.num    = 3'd1;
            res.status = ST_BAD_LETTER;
            disc_nxt   = 1'b1;
          end
        end
        MODE_HEX_X, MODE_HEX_U4, MODE_HEX_U8: begin
          if (!hx.ok) begin
            res.num    = 3'd1;
            res.status = ST_BAD_HEX;
            disc_nxt   = 1'b1;
            mode_nxt   = MODE_PLAIN;
            seen_nxt   = '0;
            acc_nxt    = '0;
          end else if (seen_inc >= need) begin
            mode_nxt = MODE_PLAIN;
            seen_nxt = '0;
            acc_nxt  = '0;
            if (mode_r == MODE_HEX_X) begin
              res.num      = 3'd1;
              res.has      = 1'b1;
              res.bytes[0] = cp[7:0];
            end else if (cp > CP_MAX) begin
              res.num    = 3'd1;
              res.status = ST_RANGE;
              disc_nxt   = 1'b1;
            end else begin
              res.num   = enc.num;
              res.has   = 1'b1;
              res.bytes = enc.bytes;
            end
          end else if (in_last) begin
            res.num    = 3'd1;
            res.status = ST_TRUNCATED;
            disc_nxt   = 1'b1;
            mode_nxt   = MODE_PLAIN;
            seen_nxt   = '0;
            acc_nxt    = '0;
          end else begin
            acc_nxt  = cp;
            seen_nxt = seen_inc[2:0];
          end
        end
        default: begin
          mode_nxt = MODE_PLAIN;
        end
      endcase
    end

    if (in_last) begin
      if (res.num == 3'd0) begin
        res.num = 3'd1;
      end
      res.str_end = 1'b1;
      mode_nxt    = MODE_PLAIN;
      seen_nxt    = '0;
      acc_nxt     = '0;
      disc_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      seen_r <= '0;
      acc_r  <= '0;
      disc_r <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      seen_r <= seen_nxt;
      acc_r  <= acc_nxt;
      disc_r <= disc_nxt;
    end
  end

  assign state_o.mode = mode_r;
  assign state_o.disc = disc_r;

endmodule

`default_nettype wire

>>> src/esd_out_buf.sv
// ============================================================================
// esd_out_buf
// Result register: holds the results of one input and sends them one by one.
// ============================================================================
`default_nettype none

module esd_out_buf
  import esd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  res_t             res_i,
  output logic             can_take,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] out_byte, [8] run_last, zero pad
  output logic [3:0]       out_tuser,  // [0] has_byte, [3:1] status
  output logic             out_tlast   // string_end
);

  logic            v_r;
  logic [1:0]      cnt_r;
  logic [1:0]      idx_r;
  logic [3:0][7:0] bytes_r;
  logic            has_r;
  status_t         status_r;
  logic            end_r;
  logic            last_beat;

  assign last_beat = (idx_r == cnt_r);
  assign can_take  = !v_r || (out_tready && last_beat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      v_r   <= 1'b1;
      cnt_r <= 2'(res_i.num - 3'd1);
      idx_r <= '0;
    end else if (v_r && out_tready) begin
      if (last_beat) begin
        v_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r  <= res_i.bytes;
      has_r    <= res_i.has;
      status_r <= res_i.status;
      end_r    <= res_i.str_end;
    end
  end

  assign out_tvalid = v_r;
  assign out_tdata  = {7'd0, last_beat, bytes_r[idx_r]};
  assign out_tuser  = {status_r, has_r};
  assign out_tlast  = last_beat && end_r;

endmodule

`default_nettype wire

>>> src/escaped_string_decoder.sv
// ============================================================================
// escaped_string_decoder
// Backslash-escape decoder for a quoted string body with UTF-8 output.
// ============================================================================
// One byte per input transaction, in_tlast on the final byte of a string.
// A byte enters an input register, is decoded in one pass against the escape
// state, and its results (zero to four) are loaded into the result register.
// A byte that yields at most one result is consumed once the result register
// can take it, so the block runs at one byte per clock while out_tready is high.
// The final digit of a \u or \U escape that encodes to k UTF-8 bytes holds the
// result register until all k drain; the next byte waits in the input register.
// Errors give a single result with has_byte low and a nonzero status; the
// rest of that string is dropped and its final byte gives one end result.
// ============================================================================
`default_nettype none

module escaped_string_decoder
  import esd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,   // in_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] out_byte, [8] run_last, zero pad
  output logic [3:0]       out_tuser,  // [0] has_byte, [3:1] status
  output logic             out_tlast   // string_end
);

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       consume;
  logic       load;
  logic       can_take;
  res_t       res;
  dec_state_t dec_state;
  logic       dec_idle;

  assign consume   = in_v_r && ((res.num == 3'd0) || can_take);
  assign load      = consume && (res.num != 3'd0);
  assign in_tready = !in_v_r || consume;
  assign dec_idle  = (dec_state.mode == MODE_PLAIN) && !dec_state.disc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (consume) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  esd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (consume),
    .in_byte (in_byte_r),
    .in_last (in_last_r),
    .res     (res),
    .state_o (dec_state)
  );

  esd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .res_i      (res),
    .can_take   (can_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`include "escaped_string_decoder_assert.svh"

  `ESD_ASSERT_SAME(a_err_single, out_tvalid && |out_tuser[3:1], !out_tuser[0] && out_tdata[8])
  `ESD_ASSERT_SAME(a_end_is_run_last, out_tvalid && out_tlast, out_tdata[8])
  `ESD_ASSERT_NEXT(a_end_clears_state, consume && in_last_r, dec_idle)

endmodule

`default_nettype wire
